FILE: hw/rtl/tim_pkg.sv
// Shared constants, codes, head position and cell conversion helpers for the
// interpreter tape memory. No dependencies.
package tim_pkg;

  localparam int TAPE_DEPTH = 1024;
  localparam int CELL_BITS  = 32;
  localparam int ADDR_BITS  = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;

  localparam logic [ADDR_BITS-1:0] LAST_POS = ADDR_BITS'(TAPE_DEPTH - 1);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CELL_BITS-1:0] cell_t;

  typedef enum logic [2:0] {
    REQ_READ  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_INC   = 3'd2,
    REQ_DEC   = 3'd3,
    REQ_RIGHT = 3'd4,
    REQ_LEFT  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NEG  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  function automatic addr_t next_pos(addr_t p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  function automatic addr_t prev_pos(addr_t p);
    return (p == '0) ? LAST_POS : p - 1'b1;
  endfunction

  // Sign-extend a 32-bit word and cut it to the cell width.
  function automatic cell_t word_to_cell(logic [31:0] w);
    logic [63:0] ext;
    ext = {{32{w[31]}}, w};
    return ext[CELL_BITS-1:0];
  endfunction

  // Sign-extend a cell and cut it to a 32-bit word.
  function automatic logic [31:0] cell_to_word(cell_t c);
    logic [63:0] ext;
    ext = {{(64-CELL_BITS){c[CELL_BITS-1]}}, c};
    return ext[31:0];
  endfunction

endpackage

FILE: hw/rtl/tim_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module tim_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/interpreter_tape_memory.sv
// Tape memory for a tape-machine interpreter: circular tape of signed cells
// under a head, with a growing window of used cells.
// Depends on tim_pkg and tim_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request word: req_type
//   and write_value. Result channel (out_valid / out_stall) returns one word
//   per request: cell_value under the head after the request, and status.
//   A word is taken at a clock edge where valid is high and stall is low.
//
//   After reset (rst_n low, synchronous) the block runs a clearing pass over
//   the tape, one cell per cycle, over all TAPE_DEPTH cells (1024); in_stall stays
//   high until it ends. Head and window restart at cell zero.
//
//   At the accepting edge the tape RAM starts a registered read of the target
//   cell; in EXEC the cell is modified and written back, and the output
//   register is loaded. out_valid rises at the edge that ends EXEC; no new
//   request is taken until the block is back in IDLE. The result sits in an
//   output register; while the receiver stalls, it holds, and a new request
//   is taken only once that register is empty or being emptied.
module interpreter_tape_memory
  import tim_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_cell_value,
  output logic [1:0]  out_status
);

  state_t      state_r, state_nxt;
  addr_t       clr_r, clr_nxt;
  addr_t       head_r, head_nxt;
  addr_t       first_r, first_nxt;
  addr_t       last_r, last_nxt;
  logic [2:0]  req_r;
  logic [31:0] wv_r;
  logic [1:0]  mstat_r, mstat_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r;
  logic [1:0]  out_status_r;

  logic        accept;
  logic        full;
  logic        ram_we;
  addr_t       ram_waddr;
  cell_t       ram_wdata;
  cell_t       ram_rdata;
  cell_t       new_cell;
  logic        mod_we;

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = (next_pos(last_r) == first_r);

  // Head and window move at accept; the RAM reads the new head cell.
  always_comb begin
    head_nxt  = head_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    mstat_nxt = mstat_r;
    if (accept) begin
      mstat_nxt = STAT_OK;
      case (in_req_type)
        REQ_RIGHT: begin
          if (head_r == last_r && full) begin
            mstat_nxt = STAT_FULL;
          end else begin
            if (head_r == last_r) begin
              last_nxt = next_pos(last_r);
            end
            head_nxt = next_pos(head_r);
          end
        end
        REQ_LEFT: begin
          if (head_r == first_r && full) begin
            mstat_nxt = STAT_FULL;
          end else begin
            if (head_r == first_r) begin
              first_nxt = prev_pos(first_r);
            end
            head_nxt = prev_pos(head_r);
          end
        end
        default: ;
      endcase
    end
  end

  // Modify the cell read back from the tape.
  always_comb begin
    new_cell = ram_rdata;
    mod_we   = 1'b0;
    case (req_r)
      REQ_WRITE: begin
        new_cell = word_to_cell(wv_r);
        mod_we   = 1'b1;
      end
      REQ_INC: begin
        new_cell = ram_rdata + 1'b1;
        mod_we   = 1'b1;
      end
      REQ_DEC: begin
        new_cell = ram_rdata - 1'b1;
        mod_we   = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = next_pos(clr_r);
        if (clr_r == LAST_POS) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_r;
    ram_wdata = new_cell;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == ST_EXEC) begin
      ram_we = mod_we;
    end
  end

  // Output register is empty whenever EXEC runs, so load it unconditionally.
  assign out_valid_nxt = (state_r == ST_EXEC) || (out_valid_r && out_stall);

  tim_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      first_r     <= '0;
      last_r      <= '0;
      mstat_r     <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      mstat_r     <= mstat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      wv_r  <= in_write_value;
    end
    if (state_r == ST_EXEC) begin
      out_value_r <= cell_to_word(new_cell);
      if (mod_we && req_r != REQ_WRITE && new_cell[CELL_BITS-1]) begin
        out_status_r <= STAT_NEG;
      end else begin
        out_status_r <= mstat_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;
  assign out_status     = out_status_r;

endmodule
